// ----- src/mgbo_pkg.sv -----
// ----------------------------------------------------------------------------
// mgbo_pkg
// Shared types, sizes and helpers of the motion gated box overlap check.
// ----------------------------------------------------------------------------
package mgbo_pkg;

  // Block sizing
  localparam int MAX_MOTION_BOXES = 16;
  localparam int GRID_COLUMNS     = 32;
  localparam int GRID_ROWS        = 24;

  // Fixed field widths
  localparam int MODE_W    = 2;
  localparam int EDGE_W    = 12;
  localparam int CHAN_W    = 12;
  localparam int PCT_W     = 7;
  localparam int MATCH_W   = 4;
  localparam int CFG_IDX_W = 2;
  localparam int CFG_DATA_W = 12;

  // Register reset values
  localparam logic [CHAN_W-1:0] CHAN_WIDTH_RST  = CHAN_W'(320);
  localparam logic [CHAN_W-1:0] CHAN_HEIGHT_RST = CHAN_W'(180);
  localparam logic [PCT_W-1:0]  DETECT_PCT_RST  = PCT_W'(7);
  localparam logic [PCT_W-1:0]  MOTION_PCT_RST  = PCT_W'(40);
  localparam int                PCT_SCALE       = 100;

  // List sizing
  localparam int IDX_W = (MAX_MOTION_BOXES > 1) ? $clog2(MAX_MOTION_BOXES) : 1;
  localparam int CNT_W = $clog2(MAX_MOTION_BOXES + 1);

  // Stored grid edges, saturated to the grid size
  localparam int COL_W  = $clog2(GRID_COLUMNS + 1);
  localparam int ROW_W  = $clog2(GRID_ROWS + 1);
  // Edges after widening an empty box by one cell
  localparam int COLX_W = $clog2(GRID_COLUMNS + 2);
  localparam int ROWX_W = $clog2(GRID_ROWS + 2);

  // Grid to pixel scaling: (edge * chan) / grid by reciprocal multiply
  localparam int COL_PROD_W = COLX_W + CHAN_W;
  localparam int ROW_PROD_W = ROWX_W + CHAN_W;
  localparam int COL_SHIFT  = COL_PROD_W + $clog2(GRID_COLUMNS);
  localparam int ROW_SHIFT  = ROW_PROD_W + $clog2(GRID_ROWS);
  localparam longint COL_RECIP_L =
    ((64'd1 << COL_SHIFT) + GRID_COLUMNS - 1) / GRID_COLUMNS;
  localparam longint ROW_RECIP_L =
    ((64'd1 << ROW_SHIFT) + GRID_ROWS - 1) / GRID_ROWS;
  localparam logic [COL_PROD_W:0] COL_RECIP = (COL_PROD_W + 1)'(COL_RECIP_L);
  localparam logic [ROW_PROD_W:0] ROW_RECIP = (ROW_PROD_W + 1)'(ROW_RECIP_L);
  localparam int COL_MUL_W = 2 * COL_PROD_W + 1;
  localparam int ROW_MUL_W = 2 * ROW_PROD_W + 1;

  // Pixel coordinates, areas and thresholds
  localparam int SC_W   = CHAN_W + 1;          // scaled edge, widened box may pass chan
  localparam int DIFF_W = SC_W + 1;            // signed edge difference
  localparam int AREA_W = 2 * DIFF_W;          // signed area
  localparam int THR_W  = AREA_W + PCT_W;      // area times percent
  localparam int DDIFF_W = CHAN_W + 1;         // signed detector edge difference
  localparam int DAREA_W = 2 * DDIFF_W;

  typedef enum logic [MODE_W-1:0] {
    MODE_CLEAR  = 2'd0,
    MODE_APPEND = 2'd1,
    MODE_CHECK  = 2'd2,
    MODE_NONE   = 2'd3
  } mode_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_CHAN_WIDTH  = 2'd0,
    CFG_CHAN_HEIGHT = 2'd1,
    CFG_DETECT_PCT  = 2'd2,
    CFG_MOTION_PCT  = 2'd3
  } cfg_idx_t;

  typedef struct packed {
    logic [COL_W-1:0] left;
    logic [ROW_W-1:0] top;
    logic [COL_W-1:0] right;
    logic [ROW_W-1:0] bottom;
  } box_t;

  typedef struct packed {
    logic [EDGE_W-1:0] left;
    logic [EDGE_W-1:0] top;
    logic [EDGE_W-1:0] right;
    logic [EDGE_W-1:0] bottom;
  } det_box_t;

  // Read request that travels with each stored box through the pipeline
  typedef struct packed {
    logic             valid;
    logic             last;
    logic [IDX_W-1:0] idx;
  } walk_tag_t;

  // Per-check settings handed to the match pipeline
  typedef struct packed {
    logic [CHAN_W-1:0] chan_width;
    logic [CHAN_W-1:0] chan_height;
    logic [PCT_W-1:0]  motion_pct;
    det_box_t          det;
    logic [THR_W-1:0]  det_thr;
    logic              det_ok;
  } match_cfg_t;

  typedef struct packed {
    logic             valid;
    logic             last;
    logic             hit;
    logic [IDX_W-1:0] idx;
  } match_res_t;

  function automatic logic [SC_W-1:0] scale_col(input logic [COL_PROD_W-1:0] p);
    logic [COL_MUL_W-1:0] prod;
    prod = COL_MUL_W'(p) * COL_MUL_W'(COL_RECIP);
    return prod[COL_SHIFT +: SC_W];
  endfunction

  function automatic logic [SC_W-1:0] scale_row(input logic [ROW_PROD_W-1:0] p);
    logic [ROW_MUL_W-1:0] prod;
    prod = ROW_MUL_W'(p) * ROW_MUL_W'(ROW_RECIP);
    return prod[ROW_SHIFT +: SC_W];
  endfunction

endpackage

// ----- src/mgbo_in_if.sv -----
// ----------------------------------------------------------------------------
// mgbo_in_if
// Request channel: list clear, motion box append or detector box check.
// ----------------------------------------------------------------------------
interface mgbo_in_if;
  logic                        valid;
  logic                        ready;
  logic [mgbo_pkg::MODE_W-1:0] mode;
  logic [mgbo_pkg::EDGE_W-1:0] box_left;
  logic [mgbo_pkg::EDGE_W-1:0] box_top;
  logic [mgbo_pkg::EDGE_W-1:0] box_right;
  logic [mgbo_pkg::EDGE_W-1:0] box_bottom;

  modport source (output valid, mode, box_left, box_top, box_right, box_bottom,
                  input ready);
  modport sink   (input valid, mode, box_left, box_top, box_right, box_bottom,
                  output ready);
endinterface

// ----- src/mgbo_out_if.sv -----
// ----------------------------------------------------------------------------
// mgbo_out_if
// Result channel: one check answer per detector box.
// ----------------------------------------------------------------------------
interface mgbo_out_if;
  logic                         valid;
  logic                         ready;
  logic                         confirmed;
  logic [mgbo_pkg::MATCH_W-1:0] match_index;

  modport source (output valid, confirmed, match_index, input ready);
  modport sink   (input valid, confirmed, match_index, output ready);
endinterface

// ----- src/mgbo_cfg_if.sv -----
// ----------------------------------------------------------------------------
// mgbo_cfg_if
// Register write channel: register index and write data.
// ----------------------------------------------------------------------------
interface mgbo_cfg_if;
  logic                            valid;
  logic                            ready;
  logic [mgbo_pkg::CFG_IDX_W-1:0]  index;
  logic [mgbo_pkg::CFG_DATA_W-1:0] data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

// ----- src/motion_gated_box_overlap_check.sv -----
// ----------------------------------------------------------------------------
// motion_gated_box_overlap_check
// Motion box list with an overlap test of detector boxes against it.
// ----------------------------------------------------------------------------
// Usage:
//   in_ch carries one request per handshake: clear the motion list, append a
//   motion box in grid cells, or check a detector box in channel pixels.
//   Clear and append give no result. A check gives one
//   result on out_ch: confirmed and the index of the first matching box.
//   cfg_ch writes the four registers by index; write them only while idle.
// Check sequence:
//   A check reads the box memory one entry per cycle and feeds each entry
//   through the six-stage match pipeline; requests are taken one at a time.
// Reset:
//   Clears the list count and loads the register defaults. The box memory is
// not cleared; only entries below the count are ever matched.
// Stalls:
//   The result sits in an output register; a new request is taken while it
//   waits, and a further check holds in its last step until the slot frees.
// ----------------------------------------------------------------------------
module motion_gated_box_overlap_check (
  input  logic              clk,
  input  logic              rst_n,
  mgbo_in_if.sink           in_ch,
  mgbo_out_if.source        out_ch,
  mgbo_cfg_if.sink          cfg_ch
);

  localparam int IDX_W = mgbo_pkg::IDX_W;
  localparam int CNT_W = mgbo_pkg::CNT_W;

  typedef enum logic [5:0] {
    S_IDLE  = 6'b000001,
    S_AREA  = 6'b000010,
    S_THR   = 6'b000100,
    S_WALK  = 6'b001000,
    S_DRAIN = 6'b010000,
    S_DONE  = 6'b100000
  } state_t;

  state_t state_r, state_nxt;

  // Configuration registers
  logic [mgbo_pkg::CHAN_W-1:0] chan_width_r, chan_height_r;
  logic [mgbo_pkg::PCT_W-1:0]  detect_pct_r, motion_pct_r;

  assign cfg_ch.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      chan_width_r  <= mgbo_pkg::CHAN_WIDTH_RST;
      chan_height_r <= mgbo_pkg::CHAN_HEIGHT_RST;
      detect_pct_r  <= mgbo_pkg::DETECT_PCT_RST;
      motion_pct_r  <= mgbo_pkg::MOTION_PCT_RST;
    end else if (cfg_ch.valid) begin
      case (mgbo_pkg::cfg_idx_t'(cfg_ch.index))
        mgbo_pkg::CFG_CHAN_WIDTH:  chan_width_r  <= cfg_ch.data[mgbo_pkg::CHAN_W-1:0];
        mgbo_pkg::CFG_CHAN_HEIGHT: chan_height_r <= cfg_ch.data[mgbo_pkg::CHAN_W-1:0];
        mgbo_pkg::CFG_DETECT_PCT:  detect_pct_r  <= cfg_ch.data[mgbo_pkg::PCT_W-1:0];
        mgbo_pkg::CFG_MOTION_PCT:  motion_pct_r  <= cfg_ch.data[mgbo_pkg::PCT_W-1:0];
        default: ;
      endcase
    end
  end

  // Request decode
  logic in_acc;
  mgbo_pkg::mode_t in_mode;

  assign in_ch.ready = (state_r == S_IDLE);
  assign in_acc      = in_ch.valid && in_ch.ready;
  assign in_mode     = mgbo_pkg::mode_t'(in_ch.mode);

  // Motion box memory and list count
  mgbo_pkg::box_t mem_r [mgbo_pkg::MAX_MOTION_BOXES];
  mgbo_pkg::box_t wr_box, rd_box_r;
  logic [CNT_W-1:0] count_r, issue_r;
  logic             mem_we;
  logic             rd_en, rd_last;
  mgbo_pkg::walk_tag_t rd_tag_r;

  always_comb begin
    wr_box.left   = (in_ch.box_left > mgbo_pkg::EDGE_W'(mgbo_pkg::GRID_COLUMNS)) ?
                    mgbo_pkg::COL_W'(mgbo_pkg::GRID_COLUMNS) :
                    in_ch.box_left[mgbo_pkg::COL_W-1:0];
    wr_box.right  = (in_ch.box_right > mgbo_pkg::EDGE_W'(mgbo_pkg::GRID_COLUMNS)) ?
                    mgbo_pkg::COL_W'(mgbo_pkg::GRID_COLUMNS) :
                    in_ch.box_right[mgbo_pkg::COL_W-1:0];
    wr_box.top    = (in_ch.box_top > mgbo_pkg::EDGE_W'(mgbo_pkg::GRID_ROWS)) ?
                    mgbo_pkg::ROW_W'(mgbo_pkg::GRID_ROWS) :
                    in_ch.box_top[mgbo_pkg::ROW_W-1:0];
    wr_box.bottom = (in_ch.box_bottom > mgbo_pkg::EDGE_W'(mgbo_pkg::GRID_ROWS)) ?
                    mgbo_pkg::ROW_W'(mgbo_pkg::GRID_ROWS) :
                    in_ch.box_bottom[mgbo_pkg::ROW_W-1:0];
  end

  assign mem_we  = in_acc && (in_mode == mgbo_pkg::MODE_APPEND) &&
                   (count_r < CNT_W'(mgbo_pkg::MAX_MOTION_BOXES));
  assign rd_en   = (state_r == S_WALK);
  assign rd_last = ((issue_r + CNT_W'(1)) == count_r);

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem_r[count_r[IDX_W-1:0]] <= wr_box;
    end
    rd_box_r <= mem_r[issue_r[IDX_W-1:0]];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r  <= '0;
      rd_tag_r <= '0;
    end else begin
      if (in_acc && (in_mode == mgbo_pkg::MODE_CLEAR)) begin
        count_r <= '0;
      end else if (mem_we) begin
        count_r <= count_r + CNT_W'(1);
      end
      rd_tag_r.valid <= rd_en;
      rd_tag_r.last  <= rd_en && rd_last;
      rd_tag_r.idx   <= issue_r[IDX_W-1:0];
    end
  end

  // Detector box and its area threshold
  mgbo_pkg::det_box_t det_r;
  logic signed [mgbo_pkg::DDIFF_W-1:0] dw, dh;
  logic signed [mgbo_pkg::DAREA_W-1:0] darea_r;
  logic [mgbo_pkg::THR_W-1:0]          dthr_r;
  logic                                det_ok_r;

  assign dw = $signed({1'b0, det_r.right})  - $signed({1'b0, det_r.left});
  assign dh = $signed({1'b0, det_r.bottom}) - $signed({1'b0, det_r.top});

  always_ff @(posedge clk) begin
    if (in_acc) begin
      det_r.left   <= in_ch.box_left;
      det_r.top    <= in_ch.box_top;
      det_r.right  <= in_ch.box_right;
      det_r.bottom <= in_ch.box_bottom;
    end
    if (state_r == S_AREA) begin
      darea_r <= dw * dh;
    end
    if (state_r == S_THR) begin
      dthr_r   <= mgbo_pkg::THR_W'(unsigned'(darea_r)) * mgbo_pkg::THR_W'(detect_pct_r);
      det_ok_r <= (darea_r > 0);
    end
  end

  // Match pipeline
  mgbo_pkg::match_cfg_t mcfg;
  mgbo_pkg::match_res_t res;

  assign mcfg.chan_width  = chan_width_r;
  assign mcfg.chan_height = chan_height_r;
  assign mcfg.motion_pct  = motion_pct_r;
  assign mcfg.det         = det_r;
  assign mcfg.det_thr     = dthr_r;
  assign mcfg.det_ok      = det_ok_r;

  mgbo_match_pipe u_match (
    .clk    (clk),
    .rst_n  (rst_n),
    .rd_tag (rd_tag_r),
    .rd_box (rd_box_r),
    .mcfg   (mcfg),
    .res    (res)
  );

  // Sequencer
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE: begin
        if (in_acc && (in_mode == mgbo_pkg::MODE_CHECK)) begin
          state_nxt = S_AREA;
        end
      end
      S_AREA: state_nxt = S_THR;
      S_THR: begin
        state_nxt = (count_r == '0) ? S_DONE : S_WALK;
      end
      S_WALK: begin
        if (rd_last) begin
          state_nxt = S_DRAIN;
        end
      end
      S_DRAIN: begin
        if (res.valid && res.last) begin
          state_nxt = S_DONE;
        end
      end
      S_DONE: begin
        if (!out_ch.valid || out_ch.ready) begin
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  // First hit wins; later hits are dropped
  logic             found_r;
  logic [IDX_W-1:0] match_idx_r;
  logic             out_valid_r;
  logic             out_conf_r;
  logic [mgbo_pkg::MATCH_W-1:0] out_idx_r;

  assign out_ch.valid       = out_valid_r;
  assign out_ch.confirmed   = out_conf_r;
  assign out_ch.match_index = out_idx_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      issue_r     <= '0;
      found_r     <= 1'b0;
      match_idx_r <= '0;
      out_valid_r <= 1'b0;
      out_conf_r  <= 1'b0;
      out_idx_r   <= '0;
    end else begin
      state_r <= state_nxt;
      if (state_r == S_THR) begin
        issue_r     <= '0;
        found_r     <= 1'b0;
        match_idx_r <= '0;
      end else begin
        if (rd_en) begin
          issue_r <= issue_r + CNT_W'(1);
        end
        if (res.valid && res.hit && !found_r) begin
          found_r     <= 1'b1;
          match_idx_r <= res.idx;
        end
      end
      if (state_r == S_DONE && (!out_valid_r || out_ch.ready)) begin
        out_valid_r <= 1'b1;
        out_conf_r  <= found_r;
        out_idx_r   <= mgbo_pkg::MATCH_W'(match_idx_r);
      end else if (out_ch.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

endmodule

// ----- src/mgbo_match_pipe.sv -----
// ----------------------------------------------------------------------------
// mgbo_match_pipe
// Six-stage pipeline that tests one stored motion box per cycle against the
// current detector box: widen, scale to pixels, overlap, areas, thresholds.
// ----------------------------------------------------------------------------
module mgbo_match_pipe (
  input  logic                   clk,
  input  logic                   rst_n,
  input  mgbo_pkg::walk_tag_t    rd_tag,
  input  mgbo_pkg::box_t         rd_box,
  input  mgbo_pkg::match_cfg_t   mcfg,
  output mgbo_pkg::match_res_t   res
);

  localparam int SC_W   = mgbo_pkg::SC_W;
  localparam int DIFF_W = mgbo_pkg::DIFF_W;
  localparam int AREA_W = mgbo_pkg::AREA_W;
  localparam int THR_W  = mgbo_pkg::THR_W;

  mgbo_pkg::walk_tag_t tag1_r, tag2_r, tag3_r, tag4_r, tag5_r;

  // Stage 1: widen empty edges, multiply by channel size
  logic [mgbo_pkg::COLX_W-1:0] right_w;
  logic [mgbo_pkg::ROWX_W-1:0] bottom_w;
  logic [mgbo_pkg::COL_PROD_W-1:0] pl1_r, pr1_r;
  logic [mgbo_pkg::ROW_PROD_W-1:0] pt1_r, pb1_r;

  always_comb begin
    right_w  = mgbo_pkg::COLX_W'(rd_box.right);
    bottom_w = mgbo_pkg::ROWX_W'(rd_box.bottom);
    if (rd_box.right == rd_box.left) begin
      right_w = mgbo_pkg::COLX_W'(rd_box.right) + mgbo_pkg::COLX_W'(1);
    end
    if (rd_box.bottom == rd_box.top) begin
      bottom_w = mgbo_pkg::ROWX_W'(rd_box.bottom) + mgbo_pkg::ROWX_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    pl1_r <= mgbo_pkg::COL_PROD_W'(rd_box.left) * mgbo_pkg::COL_PROD_W'(mcfg.chan_width);
    pr1_r <= mgbo_pkg::COL_PROD_W'(right_w) * mgbo_pkg::COL_PROD_W'(mcfg.chan_width);
    pt1_r <= mgbo_pkg::ROW_PROD_W'(rd_box.top) * mgbo_pkg::ROW_PROD_W'(mcfg.chan_height);
    pb1_r <= mgbo_pkg::ROW_PROD_W'(bottom_w) * mgbo_pkg::ROW_PROD_W'(mcfg.chan_height);
  end

  // Stage 2: divide by grid size through the reciprocal
  logic [SC_W-1:0] mx1_r, mx2_r, my1_r, my2_r;

  always_ff @(posedge clk) begin
    mx1_r <= mgbo_pkg::scale_col(pl1_r);
    mx2_r <= mgbo_pkg::scale_col(pr1_r);
    my1_r <= mgbo_pkg::scale_row(pt1_r);
    my2_r <= mgbo_pkg::scale_row(pb1_r);
  end

  // Stage 3: overlap extents and motion box extents
  logic [SC_W-1:0] dx1, dy1, dx2, dy2;
  logic [SC_W-1:0] ix1, iy1, ix2, iy2;
  logic signed [DIFF_W-1:0] iw_s, ih_s;
  logic [SC_W-1:0] iw3_r, ih3_r;
  logic signed [DIFF_W-1:0] mw3_r, mh3_r;

  always_comb begin
    dx1 = SC_W'(mcfg.det.left);
    dy1 = SC_W'(mcfg.det.top);
    dx2 = SC_W'(mcfg.det.right);
    dy2 = SC_W'(mcfg.det.bottom);
    ix1 = (mx1_r > dx1) ? mx1_r : dx1;
    iy1 = (my1_r > dy1) ? my1_r : dy1;
    ix2 = (mx2_r < dx2) ? mx2_r : dx2;
    iy2 = (my2_r < dy2) ? my2_r : dy2;
    iw_s = $signed({1'b0, ix2}) - $signed({1'b0, ix1});
    ih_s = $signed({1'b0, iy2}) - $signed({1'b0, iy1});
  end

  always_ff @(posedge clk) begin
    // clamp disjoint extents to zero
    iw3_r <= iw_s[DIFF_W-1] ? '0 : iw_s[SC_W-1:0];
    ih3_r <= ih_s[DIFF_W-1] ? '0 : ih_s[SC_W-1:0];
    mw3_r <= $signed({1'b0, mx2_r}) - $signed({1'b0, mx1_r});
    mh3_r <= $signed({1'b0, my2_r}) - $signed({1'b0, my1_r});
  end

  // Stage 4: overlap area and motion box area
  logic [2*SC_W-1:0]        inter4_r;
  logic signed [AREA_W-1:0] marea4_r;

  always_ff @(posedge clk) begin
    inter4_r <= (2*SC_W)'(iw3_r) * (2*SC_W)'(ih3_r);
    marea4_r <= mw3_r * mh3_r;
  end

  // Stage 5: scale to percent
  logic [THR_W-1:0] inter5_r, mthr5_r;
  logic             mok5_r;

  always_ff @(posedge clk) begin
    inter5_r <= THR_W'(inter4_r) * THR_W'(mgbo_pkg::PCT_SCALE);
    mthr5_r  <= THR_W'(unsigned'(marea4_r)) * THR_W'(mcfg.motion_pct);
    mok5_r   <= (marea4_r > 0);
  end

  // Stage 6: both thresholds, and the tag pipeline
  always_ff @(posedge clk) begin
    res.hit <= mcfg.det_ok && mok5_r && (inter5_r >= mcfg.det_thr) &&
               (inter5_r >= mthr5_r);
    res.idx  <= tag5_r.idx;
    res.last <= tag5_r.last;
    if (!rst_n) begin
      tag1_r    <= '0;
      tag2_r    <= '0;
      tag3_r    <= '0;
      tag4_r    <= '0;
      tag5_r    <= '0;
      res.valid <= 1'b0;
    end else begin
      tag1_r    <= rd_tag;
      tag2_r    <= tag1_r;
      tag3_r    <= tag2_r;
      tag4_r    <= tag3_r;
      tag5_r    <= tag4_r;
      res.valid <= tag5_r.valid;
    end
  end

endmodule
